// File: design/scancode_to_ascii_with_fifos_unit_assert.svh
// assertion macros for the scancode unit checker
// expects clk and rst to be visible where a macro is used
`ifndef SCANCODE_TO_ASCII_WITH_FIFOS_UNIT_ASSERT_SVH
`define SCANCODE_TO_ASCII_WITH_FIFOS_UNIT_ASSERT_SVH

// implication or plain property, checked at every clock edge out of reset
`define S2A_ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// combinational condition that must never hold at a clock edge out of reset
`define S2A_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: design/s2a_pkg.sv
// shared types, constants and key tables for the scancode unit
// no dependencies
package s2a_pkg;

  localparam int CHAR_DEPTH = 256;
  localparam int RAW_DEPTH  = 64;
  localparam int CHAR_AW    = $clog2(CHAR_DEPTH);
  localparam int RAW_AW     = $clog2(RAW_DEPTH);

  localparam int CODE_W = 7;
  localparam int CFG_AW = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_SCAN     = 2'd0,
    OP_POP_CHAR = 2'd1,
    OP_POP_RAW  = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_ARROW_UP    = 2'd0,
    REG_ARROW_DOWN  = 2'd1,
    REG_ARROW_LEFT  = 2'd2,
    REG_ARROW_RIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic     we;
    reg_idx_t idx;
    logic [7:0] data;
  } cfg_wr_t;

  localparam logic [CODE_W-1:0] KEY_LSHIFT = 7'h2A;
  localparam logic [CODE_W-1:0] KEY_RSHIFT = 7'h36;
  localparam logic [CODE_W-1:0] KEY_LCTRL  = 7'h1D;
  localparam logic [CODE_W-1:0] KEY_CAPS   = 7'h3A;
  localparam logic [CODE_W-1:0] KEY_UP     = 7'h48;
  localparam logic [CODE_W-1:0] KEY_DOWN   = 7'h50;
  localparam logic [CODE_W-1:0] KEY_LEFT   = 7'h4B;
  localparam logic [CODE_W-1:0] KEY_RIGHT  = 7'h4D;
  localparam logic [CODE_W-1:0] KEY_ALPHA_LO = 7'h10;
  localparam logic [CODE_W-1:0] KEY_ALPHA_HI = 7'h32;
  localparam logic [CODE_W-1:0] KEY_MAP_END  = 7'd58;

  localparam logic [7:0] ARROW_UP_RST    = 8'd128;
  localparam logic [7:0] ARROW_DOWN_RST  = 8'd129;
  localparam logic [7:0] ARROW_LEFT_RST  = 8'd130;
  localparam logic [7:0] ARROW_RIGHT_RST = 8'd131;

  // us layout, unshifted
  function automatic logic [7:0] lower_char(input logic [CODE_W-1:0] code);
    logic [7:0] c;
    case (code)
      7'd1:  c = 8'h1B;  7'd2:  c = 8'h31;  7'd3:  c = 8'h32;  7'd4:  c = 8'h33;
      7'd5:  c = 8'h34;  7'd6:  c = 8'h35;  7'd7:  c = 8'h36;  7'd8:  c = 8'h37;
      7'd9:  c = 8'h38;  7'd10: c = 8'h39;  7'd11: c = 8'h30;  7'd12: c = 8'h2D;
      7'd13: c = 8'h3D;  7'd14: c = 8'h08;  7'd15: c = 8'h09;  7'd16: c = 8'h71;
      7'd17: c = 8'h77;  7'd18: c = 8'h65;  7'd19: c = 8'h72;  7'd20: c = 8'h74;
      7'd21: c = 8'h79;  7'd22: c = 8'h75;  7'd23: c = 8'h69;  7'd24: c = 8'h6F;
      7'd25: c = 8'h70;  7'd26: c = 8'h5B;  7'd27: c = 8'h5D;  7'd28: c = 8'h0A;
      7'd30: c = 8'h61;  7'd31: c = 8'h73;  7'd32: c = 8'h64;  7'd33: c = 8'h66;
      7'd34: c = 8'h67;  7'd35: c = 8'h68;  7'd36: c = 8'h6A;  7'd37: c = 8'h6B;
      7'd38: c = 8'h6C;  7'd39: c = 8'h3B;  7'd40: c = 8'h27;  7'd41: c = 8'h60;
      7'd43: c = 8'h5C;  7'd44: c = 8'h7A;  7'd45: c = 8'h78;  7'd46: c = 8'h63;
      7'd47: c = 8'h76;  7'd48: c = 8'h62;  7'd49: c = 8'h6E;  7'd50: c = 8'h6D;
      7'd51: c = 8'h2C;  7'd52: c = 8'h2E;  7'd53: c = 8'h2F;  7'd55: c = 8'h2A;
      7'd57: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // us layout, shifted
  function automatic logic [7:0] upper_char(input logic [CODE_W-1:0] code);
    logic [7:0] c;
    case (code)
      7'd1:  c = 8'h1B;  7'd2:  c = 8'h21;  7'd3:  c = 8'h40;  7'd4:  c = 8'h23;
      7'd5:  c = 8'h24;  7'd6:  c = 8'h25;  7'd7:  c = 8'h5E;  7'd8:  c = 8'h26;
      7'd9:  c = 8'h2A;  7'd10: c = 8'h28;  7'd11: c = 8'h29;  7'd12: c = 8'h5F;
      7'd13: c = 8'h2B;  7'd14: c = 8'h08;  7'd15: c = 8'h09;  7'd16: c = 8'h51;
      7'd17: c = 8'h57;  7'd18: c = 8'h45;  7'd19: c = 8'h52;  7'd20: c = 8'h54;
      7'd21: c = 8'h59;  7'd22: c = 8'h55;  7'd23: c = 8'h49;  7'd24: c = 8'h4F;
      7'd25: c = 8'h50;  7'd26: c = 8'h7B;  7'd27: c = 8'h7D;  7'd28: c = 8'h0A;
      7'd30: c = 8'h41;  7'd31: c = 8'h53;  7'd32: c = 8'h44;  7'd33: c = 8'h46;
      7'd34: c = 8'h47;  7'd35: c = 8'h48;  7'd36: c = 8'h4A;  7'd37: c = 8'h4B;
      7'd38: c = 8'h4C;  7'd39: c = 8'h3A;  7'd40: c = 8'h22;  7'd41: c = 8'h7E;
      7'd43: c = 8'h7C;  7'd44: c = 8'h5A;  7'd45: c = 8'h58;  7'd46: c = 8'h43;
      7'd47: c = 8'h56;  7'd48: c = 8'h42;  7'd49: c = 8'h4E;  7'd50: c = 8'h4D;
      7'd51: c = 8'h3C;  7'd52: c = 8'h3E;  7'd53: c = 8'h3F;  7'd55: c = 8'h2A;
      7'd57: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: design/s2a_ctrl.sv
// controller state machine for the scancode unit
// depends on s2a_pkg
module s2a_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output s2a_pkg::ctrl_cmd_t cmd
);

  s2a_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= s2a_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      s2a_pkg::ST_IDLE: begin
        if (start) state_next = s2a_pkg::ST_EXEC;
      end
      s2a_pkg::ST_EXEC: state_next = s2a_pkg::ST_RESP;
      s2a_pkg::ST_RESP: state_next = s2a_pkg::ST_IDLE;
      default:          state_next = s2a_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    done      = 1'b0;
    cmd.latch = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state)
      s2a_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      s2a_pkg::ST_EXEC: cmd.exec = 1'b1;
      s2a_pkg::ST_RESP: done = 1'b1;
      default:          busy = 1'b1;
    endcase
  end

endmodule

// File: design/s2a_datapath.sv
// datapath: modifier flags, key tables, character ring and raw event ring
// depends on s2a_pkg
module s2a_datapath (
  input  logic               clk,
  input  logic               rst,
  input  s2a_pkg::ctrl_cmd_t cmd,
  input  logic [1:0]         operation,
  input  logic [7:0]         scan_byte,
  input  s2a_pkg::cfg_wr_t   cfg_wr,
  input  s2a_pkg::reg_idx_t  cfg_rd_idx,
  output logic [7:0]         cfg_rd_data,
  output logic [7:0]         char_data,
  output logic               char_valid,
  output logic [6:0]         raw_code,
  output logic               raw_pressed,
  output logic               raw_valid,
  output logic               shift_held,
  output logic               ctrl_held,
  output logic               caps_on,
  output logic               chars_waiting,
  output logic               raw_waiting
);

  localparam int CAW = s2a_pkg::CHAR_AW;
  localparam int RAW = s2a_pkg::RAW_AW;
  localparam int CW  = s2a_pkg::CODE_W;

  logic [7:0] char_mem [s2a_pkg::CHAR_DEPTH];
  logic [7:0] raw_mem  [s2a_pkg::RAW_DEPTH];

  logic [7:0] arrow_up, arrow_down, arrow_left, arrow_right;
  s2a_pkg::op_t op;
  logic [7:0]   byte_q;

  logic [CAW-1:0] char_head, char_tail, char_head_next, char_tail_next;
  logic [CAW-1:0] char_head_inc, char_tail_inc;
  logic [RAW-1:0] evt_head, evt_tail, evt_tail_next, evt_head_inc, evt_tail_inc;
  logic shift_flag, ctrl_flag, caps_flag;
  logic shift_flag_next, ctrl_flag_next, caps_flag_next;
  logic cval, rval, cval_next, rval_next;
  logic [7:0] char_rd, raw_rd;

  logic [CW-1:0] code;
  logic          rel, upper, is_scan, alpha;
  logic          char_push, char_we, raw_we;
  logic [7:0]    char_wdata, mapped;
  logic          char_full, raw_full, char_empty, raw_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      arrow_up    <= s2a_pkg::ARROW_UP_RST;
      arrow_down  <= s2a_pkg::ARROW_DOWN_RST;
      arrow_left  <= s2a_pkg::ARROW_LEFT_RST;
      arrow_right <= s2a_pkg::ARROW_RIGHT_RST;
    end else if (cfg_wr.we) begin
      unique case (cfg_wr.idx)
        s2a_pkg::REG_ARROW_UP:    arrow_up    <= cfg_wr.data;
        s2a_pkg::REG_ARROW_DOWN:  arrow_down  <= cfg_wr.data;
        s2a_pkg::REG_ARROW_LEFT:  arrow_left  <= cfg_wr.data;
        s2a_pkg::REG_ARROW_RIGHT: arrow_right <= cfg_wr.data;
        default:                  arrow_up    <= arrow_up;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_rd_idx)
      s2a_pkg::REG_ARROW_UP:    cfg_rd_data = arrow_up;
      s2a_pkg::REG_ARROW_DOWN:  cfg_rd_data = arrow_down;
      s2a_pkg::REG_ARROW_LEFT:  cfg_rd_data = arrow_left;
      s2a_pkg::REG_ARROW_RIGHT: cfg_rd_data = arrow_right;
      default:                  cfg_rd_data = 8'h00;
    endcase
  end

  // access latched at the accepting edge
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op     <= s2a_pkg::op_t'(operation);
      byte_q <= scan_byte;
    end
  end

  assign char_head_inc = (char_head == CAW'(s2a_pkg::CHAR_DEPTH - 1)) ? '0 : char_head + 1'b1;
  assign char_tail_inc = (char_tail == CAW'(s2a_pkg::CHAR_DEPTH - 1)) ? '0 : char_tail + 1'b1;
  assign evt_head_inc  = (evt_head == RAW'(s2a_pkg::RAW_DEPTH - 1)) ? '0 : evt_head + 1'b1;
  assign evt_tail_inc  = (evt_tail == RAW'(s2a_pkg::RAW_DEPTH - 1)) ? '0 : evt_tail + 1'b1;

  assign char_full  = (char_head_inc == char_tail);
  assign raw_full   = (evt_head_inc == evt_tail);
  assign char_empty = (char_head == char_tail);
  assign raw_empty  = (evt_head == evt_tail);

  assign code    = byte_q[6:0];
  assign rel     = byte_q[7];
  assign is_scan = cmd.exec && (op == s2a_pkg::OP_SCAN);
  assign alpha   = (code >= s2a_pkg::KEY_ALPHA_LO) && (code <= s2a_pkg::KEY_ALPHA_HI);
  // caps lock flips shift for codes 0x10..0x32 only, which includes some punctuation keys
  assign upper   = shift_flag ^ (caps_flag && alpha);
  assign mapped  = upper ? s2a_pkg::upper_char(code) : s2a_pkg::lower_char(code);

  always_comb begin
    shift_flag_next = shift_flag;
    ctrl_flag_next  = ctrl_flag;
    caps_flag_next  = caps_flag;
    char_push       = 1'b0;
    char_wdata      = mapped;
    if (is_scan) begin
      if (code == s2a_pkg::KEY_LSHIFT || code == s2a_pkg::KEY_RSHIFT) begin
        shift_flag_next = !rel;
      end else if (code == s2a_pkg::KEY_LCTRL) begin
        ctrl_flag_next = !rel;
      end else if (code == s2a_pkg::KEY_CAPS) begin
        if (!rel) caps_flag_next = !caps_flag;
      end else if (!rel) begin
        if (code == s2a_pkg::KEY_UP) begin
          char_push  = 1'b1;
          char_wdata = arrow_up;
        end else if (code == s2a_pkg::KEY_DOWN) begin
          char_push  = 1'b1;
          char_wdata = arrow_down;
        end else if (code == s2a_pkg::KEY_LEFT) begin
          char_push  = 1'b1;
          char_wdata = arrow_left;
        end else if (code == s2a_pkg::KEY_RIGHT) begin
          char_push  = 1'b1;
          char_wdata = arrow_right;
        end else if (code < s2a_pkg::KEY_MAP_END) begin
          char_push = (mapped != 8'h00);
        end
      end
    end
  end

  assign char_we = char_push && !char_full;
  assign raw_we  = is_scan && !raw_full;

  always_comb begin
    char_head_next = char_we ? char_head_inc : char_head;
    char_tail_next = char_tail;
    evt_tail_next  = evt_tail;
    cval_next      = cval;
    rval_next      = rval;
    if (cmd.exec) begin
      cval_next = (op == s2a_pkg::OP_POP_CHAR) && !char_empty;
      rval_next = (op == s2a_pkg::OP_POP_RAW) && !raw_empty;
      if (cval_next) char_tail_next = char_tail_inc;
      if (rval_next) evt_tail_next = evt_tail_inc;
      if (op == s2a_pkg::OP_CLEAR) begin
        char_head_next = '0;
        char_tail_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_head  <= '0;
      char_tail  <= '0;
      evt_head   <= '0;
      evt_tail   <= '0;
      shift_flag <= 1'b0;
      ctrl_flag  <= 1'b0;
      caps_flag  <= 1'b0;
      cval       <= 1'b0;
      rval       <= 1'b0;
    end else begin
      char_head  <= char_head_next;
      char_tail  <= char_tail_next;
      evt_head   <= raw_we ? evt_head_inc : evt_head;
      evt_tail   <= evt_tail_next;
      shift_flag <= shift_flag_next;
      ctrl_flag  <= ctrl_flag_next;
      caps_flag  <= caps_flag_next;
      cval       <= cval_next;
      rval       <= rval_next;
    end
  end

  // ring memories, read data captured at the pre-pop tail
  always_ff @(posedge clk) begin
    if (char_we) char_mem[char_head] <= char_wdata;
    char_rd <= char_mem[char_tail];
  end

  always_ff @(posedge clk) begin
    if (raw_we) raw_mem[evt_head] <= {!rel, code};
    raw_rd <= raw_mem[evt_tail];
  end

  assign char_data     = cval ? char_rd : 8'h00;
  assign char_valid    = cval;
  assign raw_code      = rval ? raw_rd[6:0] : 7'h00;
  assign raw_pressed   = rval && raw_rd[7];
  assign raw_valid     = rval;
  assign shift_held    = shift_flag;
  assign ctrl_held     = ctrl_flag;
  assign caps_on       = caps_flag;
  assign chars_waiting = !char_empty;
  assign raw_waiting   = !raw_empty;

endmodule

// File: design/scancode_to_ascii_with_fifos_unit.sv
// the done strobe comes in the response state, which follows the execute state entered at the accepting edge
// one access at a time (accept, execute, ring read register); start is taken only in the idle state
// the ring memories read through a registered port, which sets the execute step
// reset clears ring pointers, modifier flags and loads arrow codes 128..131
// ring contents are not cleared; the receiver cannot stall, done lasts one cycle
module scancode_to_ascii_with_fifos_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [7:0]  scan_byte,
  output logic        done,
  output logic [7:0]  char_data,
  output logic        char_valid,
  output logic [6:0]  raw_code,
  output logic        raw_pressed,
  output logic        raw_valid,
  output logic        shift_held,
  output logic        ctrl_held,
  output logic        caps_on,
  output logic        chars_waiting,
  output logic        raw_waiting,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  s2a_pkg::ctrl_cmd_t cmd;
  s2a_pkg::cfg_wr_t   cfg_wr;
  logic [7:0]         cfg_rd_data;

  assign pready      = 1'b1;
  assign cfg_wr.we   = psel && penable && pwrite && pready;
  assign cfg_wr.idx  = s2a_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr.data = pwdata[7:0];
  assign prdata      = {24'h000000, cfg_rd_data};

  s2a_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  s2a_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .operation     (operation),
    .scan_byte     (scan_byte),
    .cfg_wr        (cfg_wr),
    .cfg_rd_idx    (s2a_pkg::reg_idx_t'(paddr[3:2])),
    .cfg_rd_data   (cfg_rd_data),
    .char_data     (char_data),
    .char_valid    (char_valid),
    .raw_code      (raw_code),
    .raw_pressed   (raw_pressed),
    .raw_valid     (raw_valid),
    .shift_held    (shift_held),
    .ctrl_held     (ctrl_held),
    .caps_on       (caps_on),
    .chars_waiting (chars_waiting),
    .raw_waiting   (raw_waiting)
  );

endmodule

// File: design/s2a_checker.sv
// port-level checks for the scancode unit, bound to the top level
// depends on scancode_to_ascii_with_fifos_unit_assert.svh
`include "scancode_to_ascii_with_fifos_unit_assert.svh"

module s2a_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic char_valid,
  input logic raw_valid
);

  `S2A_ASSERT_PROP(a_accept_busy, (start && !busy) |=> busy, "no busy after accepted transfer")
  `S2A_ASSERT_PROP(a_accept_done, (start && !busy) |-> ##2 done, "result not two cycles after accept")
  `S2A_ASSERT_PROP(a_done_idle, done |=> (!done && !busy), "unit not idle after result")
  `S2A_ASSERT_NEVER(a_one_pop, char_valid && raw_valid, "character and raw event popped together")

endmodule

bind scancode_to_ascii_with_fifos_unit s2a_checker u_s2a_checker (.*);
